@@ hdl/bcsp_pkg.sv @@
// Package for the six-step commutation and speed/position controller.
// Types, register indexes, control codes and lookup tables; no dependencies.
package bcsp_pkg;

    localparam int FRAC_BITS_DEF      = 16;
    localparam int INTEGRAL_LIMIT_DEF = 880;

    localparam logic [2:0] ROTOR_BAD = 3'd7;

    localparam logic [5:0] DRIVE_TBL [8] = '{6'h12, 6'h18, 6'h09, 6'h21,
                                             6'h24, 6'h06, 6'h00, 6'h00};
    localparam logic [2:0] ROTOR_TBL [8] = '{3'd7, 3'd5, 3'd3, 3'd4,
                                             3'd1, 3'd0, 3'd2, 3'd7};

    localparam logic [2:0] REG_MODE      = 3'd0;
    localparam logic [2:0] REG_TGT_SPEED = 3'd1;
    localparam logic [2:0] REG_TGT_POS   = 3'd2;
    localparam logic [2:0] REG_SPEED_KP  = 3'd3;
    localparam logic [2:0] REG_SPEED_KI  = 3'd4;
    localparam logic [2:0] REG_POS_KP    = 3'd5;
    localparam logic [2:0] REG_POS_KD    = 3'd6;
    localparam logic [2:0] REG_MAX_DUTY  = 3'd7;

    localparam logic [2:0] MODE_HOLD  = 3'd0;
    localparam logic [2:0] MODE_FULL  = 3'd1;
    localparam logic [2:0] MODE_SPEED = 3'd2;
    localparam logic [2:0] MODE_POS   = 3'd3;
    localparam logic [2:0] MODE_BOTH  = 3'd4;

    typedef struct packed {
        logic        kind;
        logic [2:0]  hall_bits;
        logic [19:0] interval_us;
    } t_in;

    typedef struct packed {
        logic [5:0]         drive_pattern;
        logic [15:0]        duty;
        logic signed [31:0] position;
        logic signed [31:0] velocity;
        logic               forward;
        logic               hall_invalid;
    } t_out;

    typedef enum logic [4:0] {
        ST_IDLE, ST_HALL, ST_VMUL, ST_VDIV, ST_VWAIT, ST_VFIN, ST_SZERO,
        ST_S1, ST_S2, ST_S3, ST_S4, ST_PDIV, ST_P2, ST_P3, ST_P4,
        ST_P5, ST_FIN, ST_DONE
    } t_state;

    typedef enum logic [4:0] {
        OP_NONE, OP_HALL, OP_VMUL, OP_VDIV, OP_VFIN, OP_SZERO,
        OP_S1, OP_S2, OP_S3, OP_S4, OP_PDIV, OP_P2, OP_P3, OP_P4, OP_P5, OP_FIN
    } t_op;

    typedef struct packed {
        t_op  op;
        logic load_in;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic       kind;
        logic [2:0] mode;
        logic       spd_zero;
        logic       div_busy;
        logic       out_free;
    } t_sts;

endpackage

@@ hdl/bldc_commutation_speed_position_ctrl.sv @@
// Six-step hall commutation with PI speed and PD position control. One
// request at a time; a tick request waits on the bit-serial divider that
// computes velocity, while the position scaling by 1/6 is a single
// reciprocal multiply. A stalled output delays the end of the request.
// Each request returns one result through an output register; the next
// request can be taken while that result waits. Config writes are always ready.
// Depends on bcsp_pkg, bcsp_ctrl and bcsp_dp.
module bldc_commutation_speed_position_ctrl import bcsp_pkg::*; #(
    parameter int FRAC_BITS      = FRAC_BITS_DEF,
    parameter int INTEGRAL_LIMIT = INTEGRAL_LIMIT_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_in         i_in_data,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_out        o_out_data
);
    t_cmd cmd;
    t_sts sts;

    assign o_cfg_ready = 1'b1;

    bcsp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_sts      (sts),
        .o_in_stall (o_in_stall),
        .o_cmd      (cmd)
    );

    bcsp_dp #(
        .FRAC_BITS      (FRAC_BITS),
        .INTEGRAL_LIMIT (INTEGRAL_LIMIT)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_data   (i_in_data),
        .i_out_stall (i_out_stall),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );
endmodule

@@ hdl/bcsp_div.sv @@
// Bit-serial restoring divider, one quotient bit per cycle.
// Uses no package items.
module bcsp_div #(
    parameter int NUM_W = 67,
    parameter int DEN_W = 23
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic             o_busy,
    output logic [NUM_W-1:0] o_quo
);
    localparam int CNT_W = $clog2(NUM_W + 1);

    logic             r_busy;
    logic [CNT_W-1:0] r_cnt;
    logic [NUM_W-1:0] r_num;
    logic [DEN_W-1:0] r_rem;
    logic [DEN_W-1:0] r_den;
    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   n_rem;
    logic             qbit;

    always_comb begin
        trial = {r_rem, r_num[NUM_W-1]};
        qbit  = trial >= {1'b0, r_den};
        n_rem = qbit ? trial - {1'b0, r_den} : trial;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_start) begin
            r_busy <= 1'b1;
        end else if (r_busy && r_cnt == CNT_W'(1)) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_num;
            r_rem <= '0;
            r_den <= i_den;
            r_cnt <= CNT_W'(NUM_W);
        end else if (r_busy) begin
            r_num <= {r_num[NUM_W-2:0], qbit};
            r_rem <= n_rem[DEN_W-1:0];
            r_cnt <= r_cnt - CNT_W'(1);
        end
    end

    assign o_busy = r_busy;
    assign o_quo  = r_num;
endmodule

@@ hdl/bcsp_dp.sv @@
// Datapath: configuration registers, motor state, shared multiplier,
// divider and output register. Depends on bcsp_pkg and bcsp_div.
module bcsp_dp import bcsp_pkg::*; #(
    parameter int FRAC_BITS      = FRAC_BITS_DEF,
    parameter int INTEGRAL_LIMIT = INTEGRAL_LIMIT_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    input  t_in         i_in_data,
    input  logic        i_out_stall,
    input  t_cmd        i_cmd,
    output t_sts        o_sts,
    output logic        o_out_valid,
    output t_out        o_out_data
);
    localparam int MAG_W = 51;
    localparam int NUM_W = MAG_W + FRAC_BITS;
    localparam int DEN_W = 23;
    localparam int PA_W  = 34;
    localparam int PB_W  = 24;
    localparam int PR_W  = PA_W + PB_W + 1;
    localparam int RAW_W = PR_W + 1;
    localparam int HW    = FRAC_BITS + 32;
    localparam int EW    = HW + 1;
    localparam int IS_W  = 37;
    localparam int SCL   = FRAC_BITS - 1;
    localparam logic [HW-1:0] THIRD_1 = HW'((longint'(1) <<< SCL) / 3);
    localparam logic [HW-1:0] THIRD_2 = HW'((longint'(2) <<< SCL) / 3);
    localparam logic [31:0]   RECIP_3 = 32'haaaa_aaab;
    localparam longint LIM_FULL = longint'(INTEGRAL_LIMIT) <<< FRAC_BITS;
    localparam longint LIM      = (LIM_FULL > 64'sd2147483647) ? 64'sd2147483647 : LIM_FULL;
    localparam logic signed [IS_W-1:0] LIM_P = IS_W'(LIM);
    localparam logic signed [IS_W-1:0] LIM_N = -IS_W'(LIM);

    // configuration
    logic [2:0]         r_mode;
    logic signed [31:0] r_tgt_spd, r_tgt_pos;
    logic [23:0]        r_skp, r_ski, r_pkp, r_pkd;
    logic [15:0]        r_max_duty;

    // motor state
    logic [2:0]         r_last_rotor;
    logic signed [31:0] r_count, r_tick_pos, r_integ, r_last_perr, r_vel;
    logic               r_fwd, r_invalid;
    logic [15:0]        r_duty;
    logic [5:0]         r_drive;

    // work registers
    t_in                    r_in;
    logic signed [PR_W-1:0] r_prod, r_acc;
    logic                   r_neg;
    logic [DEN_W-1:0]       r_den;
    logic signed [32:0]     r_err, r_diff;
    logic signed [31:0]     r_perr;
    logic signed [HW-1:0]   r_here;
    logic [15:0]            r_vd, r_rd;
    t_out                   r_out;
    logic                   r_out_valid;

    logic signed [PA_W-1:0] mul_a;
    logic [PB_W-1:0]        mul_b;
    logic signed [PR_W-1:0] mul_ax, mul_bx, mul_p;

    logic [2:0]         rotor;
    logic signed [3:0]  rot_d;
    logic [3:0]         drv_idx;
    logic signed [31:0] delta;
    logic [31:0]        delta_abs, cnt_abs, vmag;
    logic [19:0]        ivl;
    logic [DEN_W-1:0]   den;
    logic               div_start, div_busy;
    logic [NUM_W-1:0]   div_num, div_quo;
    logic [DEN_W-1:0]   div_den;
    logic signed [31:0] vel_n;
    logic [63:0]        q3_prod;
    logic [31:0]        q3, rem3;
    logic [HW-1:0]      here_mag;
    logic signed [EW-1:0] perr_w;
    logic signed [31:0] perr_sat;
    logic signed [32:0] tgt_abs, vel_abs;
    logic signed [IS_W-1:0] isum;
    logic signed [31:0] integ_n;
    logic signed [RAW_W-1:0] raw;
    logic [RAW_W-1:0]   raw_abs, raw_sh;
    logic [15:0]        raw_cap;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= MODE_HOLD;
            r_tgt_spd  <= '0;
            r_tgt_pos  <= '0;
            r_skp      <= '0;
            r_ski      <= '0;
            r_pkp      <= '0;
            r_pkd      <= '0;
            r_max_duty <= 16'hffff;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_MODE:      r_mode     <= i_cfg_data[2:0];
                REG_TGT_SPEED: r_tgt_spd  <= i_cfg_data;
                REG_TGT_POS:   r_tgt_pos  <= i_cfg_data;
                REG_SPEED_KP:  r_skp      <= i_cfg_data[23:0];
                REG_SPEED_KI:  r_ski      <= i_cfg_data[23:0];
                REG_POS_KP:    r_pkp      <= i_cfg_data[23:0];
                REG_POS_KD:    r_pkd      <= i_cfg_data[23:0];
                REG_MAX_DUTY:  r_max_duty <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // shared multiplier
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (i_cmd.op)
            OP_VMUL: begin
                mul_a = PA_W'(delta_abs);
                mul_b = PB_W'(1000000);
            end
            OP_S2: begin
                mul_a = PA_W'(r_err);
                mul_b = r_skp;
            end
            OP_S3: begin
                mul_a = PA_W'(r_integ);
                mul_b = r_ski;
            end
            OP_P3: begin
                mul_a = PA_W'(r_perr);
                mul_b = r_pkp;
            end
            OP_P4: begin
                mul_a = PA_W'(r_diff);
                mul_b = r_pkd;
            end
            default: ;
        endcase
        mul_ax = PR_W'(mul_a);
        mul_bx = PR_W'($signed({1'b0, mul_b}));
        mul_p  = mul_ax * mul_bx;
    end

    // hall decode
    always_comb begin
        rotor   = ROTOR_TBL[r_in.hall_bits];
        rot_d   = $signed({1'b0, rotor}) - $signed({1'b0, r_last_rotor});
        drv_idx = {1'b0, rotor} + (r_fwd ? 4'd2 : 4'd4);
        if (drv_idx >= 4'd6) begin
            drv_idx = drv_idx - 4'd6;
        end
    end

    // velocity and position terms
    always_comb begin
        delta     = r_count - r_tick_pos;
        delta_abs = delta[31] ? 32'(-delta) : 32'(delta);
        cnt_abs   = r_count[31] ? 32'(-r_count) : 32'(r_count);
        ivl       = (r_in.interval_us == '0) ? 20'd1 : r_in.interval_us;
        den       = (DEN_W'(ivl) << 2) + (DEN_W'(ivl) << 1);
        div_start = (i_cmd.op == OP_VDIV);
        div_num   = NUM_W'(r_prod[MAG_W-1:0]) << FRAC_BITS;
        div_den   = r_den;
        // |count| * 2^FRAC_BITS / 6 = (|count| / 3) * 2^(FRAC_BITS-1) + remainder term
        q3_prod  = 64'(cnt_abs) * 64'(RECIP_3);
        q3       = {1'b0, q3_prod[63:33]};
        rem3     = cnt_abs - ((q3 << 1) + q3);
        here_mag = (HW'(q3) << SCL) + ((rem3[1:0] == 2'd2) ? THIRD_2 :
                                      ((rem3[1:0] == 2'd1) ? THIRD_1 : '0));
        vmag  = (|div_quo[NUM_W-1:31]) ? 32'h8000_0000 : {1'b0, div_quo[30:0]};
        vel_n = r_neg ? -$signed(vmag) : (vmag[31] ? 32'sh7fff_ffff : $signed(vmag));
        perr_w = EW'(r_tgt_pos) - EW'(r_here);
        if (&perr_w[EW-1:31] || ~|perr_w[EW-1:31]) begin
            perr_sat = perr_w[31:0];
        end else begin
            perr_sat = perr_w[EW-1] ? 32'sh8000_0000 : 32'sh7fff_ffff;
        end
    end

    // speed loop and output scaling
    always_comb begin
        tgt_abs = r_tgt_spd[31] ? -33'(r_tgt_spd) : 33'(r_tgt_spd);
        vel_abs = r_vel[31] ? -33'(r_vel) : 33'(r_vel);
        isum    = IS_W'(r_integ) + (IS_W'(r_err) <<< 3) + (IS_W'(r_err) <<< 1);
        if (isum > LIM_P) begin
            integ_n = 32'(LIM_P);
        end else if (isum < LIM_N) begin
            integ_n = 32'(LIM_N);
        end else begin
            integ_n = isum[31:0];
        end
        raw     = RAW_W'(r_acc) + RAW_W'(r_prod);
        raw_abs = raw[RAW_W-1] ? RAW_W'(-raw) : RAW_W'(raw);
        raw_sh  = raw_abs >> FRAC_BITS;
        raw_cap = (raw_sh > RAW_W'(r_max_duty)) ? r_max_duty : raw_sh[15:0];
    end

    bcsp_div #(
        .NUM_W (NUM_W),
        .DEN_W (DEN_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_busy  (div_busy),
        .o_quo   (div_quo)
    );

    // motor state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_rotor <= '0;
            r_count      <= '0;
            r_tick_pos   <= '0;
            r_fwd        <= 1'b1;
            r_integ      <= '0;
            r_last_perr  <= '0;
            r_duty       <= '0;
            r_vel        <= '0;
            r_drive      <= '0;
            r_invalid    <= 1'b0;
        end else begin
            if (i_cmd.load_in) begin
                r_invalid <= 1'b0;
            end
            case (i_cmd.op)
                OP_HALL: begin
                    if (rotor == ROTOR_BAD) begin
                        r_invalid <= 1'b1;
                        r_drive   <= '0;
                    end else begin
                        r_drive      <= DRIVE_TBL[drv_idx[2:0]];
                        r_last_rotor <= rotor;
                        if (rot_d == 4'sd5) begin
                            r_count <= r_count - 32'sd1;
                        end else if (rot_d == -4'sd5) begin
                            r_count <= r_count + 32'sd1;
                        end else begin
                            r_count <= r_count + 32'(rot_d);
                        end
                    end
                end
                OP_VFIN: begin
                    r_vel      <= vel_n;
                    r_tick_pos <= r_count;
                end
                OP_S1:  r_fwd <= ~r_tgt_spd[31];
                OP_S2:  r_integ <= integ_n;
                OP_P3:  r_last_perr <= r_perr;
                OP_P5:  r_fwd <= ~raw[RAW_W-1];
                OP_FIN: begin
                    case (r_mode)
                        MODE_FULL:  r_duty <= r_max_duty;
                        MODE_SPEED: r_duty <= r_vd;
                        MODE_POS:   r_duty <= r_rd;
                        MODE_BOTH: begin
                            if (!r_vel[31]) begin
                                r_duty <= (r_vd < r_rd) ? r_vd : r_rd;
                            end else begin
                                r_duty <= (r_vd > r_rd) ? r_vd : r_rd;
                            end
                        end
                        default: ;
                    endcase
                end
                default: ;
            endcase
        end
    end

    // work registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_in <= i_in_data;
        end
        case (i_cmd.op)
            OP_VMUL: begin
                r_prod <= mul_p;
                r_neg  <= delta[31];
                r_den  <= den;
            end
            OP_PDIV:  r_here <= r_count[31] ? -$signed(here_mag) : $signed(here_mag);
            OP_SZERO: r_vd  <= r_max_duty;
            OP_S1:    r_err <= tgt_abs - vel_abs;
            OP_S2:    r_prod <= mul_p;
            OP_S3, OP_P4: begin
                r_acc  <= r_prod;
                r_prod <= mul_p;
            end
            OP_S4:    r_vd <= raw[RAW_W-1] || raw == '0 ? 16'd0 : raw_cap;
            OP_P2:    r_perr <= perr_sat;
            OP_P3: begin
                r_prod <= mul_p;
                r_diff <= 33'(r_perr) - 33'(r_last_perr);
            end
            OP_P5:    r_rd <= raw_cap;
            default: ;
        endcase
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out <= '{drive_pattern: r_drive, duty: r_duty, position: r_count,
                       velocity: r_vel, forward: r_fwd, hall_invalid: r_invalid};
        end
    end

    assign o_sts = '{kind: i_in_data.kind, mode: r_mode, spd_zero: (r_tgt_spd == '0),
                     div_busy: div_busy, out_free: (!r_out_valid || !i_out_stall)};
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
endmodule

@@ hdl/bcsp_ctrl.sv @@
// Controller state machine sequencing hall and tick requests.
// Depends on bcsp_pkg.
module bcsp_ctrl import bcsp_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  t_sts i_sts,
    output logic o_in_stall,
    output t_cmd o_cmd
);
    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = i_sts.kind ? ST_VMUL : ST_HALL;
                end
            end
            ST_HALL:  n_state = ST_DONE;
            ST_VMUL:  n_state = ST_VDIV;
            ST_VDIV:  n_state = ST_VWAIT;
            ST_VWAIT: n_state = i_sts.div_busy ? ST_VWAIT : ST_VFIN;
            ST_VFIN: begin
                unique case (i_sts.mode)
                    MODE_SPEED, MODE_BOTH: n_state = i_sts.spd_zero ? ST_SZERO : ST_S1;
                    MODE_POS:              n_state = ST_PDIV;
                    default:               n_state = ST_FIN;
                endcase
            end
            ST_S1:    n_state = ST_S2;
            ST_S2:    n_state = ST_S3;
            ST_S3:    n_state = ST_S4;
            ST_SZERO, ST_S4: n_state = (i_sts.mode == MODE_BOTH) ? ST_PDIV : ST_FIN;
            ST_PDIV:  n_state = ST_P2;
            ST_P2:    n_state = ST_P3;
            ST_P3:    n_state = ST_P4;
            ST_P4:    n_state = ST_P5;
            ST_P5:    n_state = ST_FIN;
            ST_FIN:   n_state = ST_DONE;
            ST_DONE:  n_state = i_sts.out_free ? ST_IDLE : ST_DONE;
            default:  n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd          = '{op: OP_NONE, load_in: 1'b0, load_out: 1'b0};
        o_in_stall     = (r_state != ST_IDLE);
        unique case (r_state)
            ST_IDLE:  o_cmd.load_in  = i_in_valid;
            ST_HALL:  o_cmd.op       = OP_HALL;
            ST_VMUL:  o_cmd.op       = OP_VMUL;
            ST_VDIV:  o_cmd.op       = OP_VDIV;
            ST_VFIN:  o_cmd.op       = OP_VFIN;
            ST_SZERO: o_cmd.op       = OP_SZERO;
            ST_S1:    o_cmd.op       = OP_S1;
            ST_S2:    o_cmd.op       = OP_S2;
            ST_S3:    o_cmd.op       = OP_S3;
            ST_S4:    o_cmd.op       = OP_S4;
            ST_PDIV:  o_cmd.op       = OP_PDIV;
            ST_P2:    o_cmd.op       = OP_P2;
            ST_P3:    o_cmd.op       = OP_P3;
            ST_P4:    o_cmd.op       = OP_P4;
            ST_P5:    o_cmd.op       = OP_P5;
            ST_FIN:   o_cmd.op       = OP_FIN;
            ST_DONE:  o_cmd.load_out = i_sts.out_free;
            default: ;
        endcase
    end
endmodule

@@ hdl/bcsp_chk.sv @@
// Port-level checker for the commutation controller, bound to the top level.
// Depends on bcsp_pkg.
module bcsp_chk import bcsp_pkg::*; (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_stall,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input t_out        o_out_data
);
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_out_data))
        else $error("stalled result changed");

    a_invalid_off: assert property (@(posedge i_clk)
        o_out_valid && o_out_data.hall_invalid |-> o_out_data.drive_pattern == 6'd0)
        else $error("bridge driven on invalid hall code");

    a_busy_after: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("request taken while busy");

    a_reset_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");
endmodule

bind bldc_commutation_speed_position_ctrl bcsp_chk u_chk (.*);

@@ bench/bldc_commutation_speed_position_ctrl_test.sv @@
// Self-checking bench for the six-step commutation and speed/position controller.
// A local model predicts every result; requests and results move under random gaps.
// Depends on bcsp_pkg and bldc_commutation_speed_position_ctrl.
module bldc_commutation_speed_position_ctrl_test;
    import bcsp_pkg::*;

    localparam int FB = 16;
    localparam int ILIM = 880;
    localparam longint CYCLE_LIMIT = 2000000;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index;
    logic [31:0] i_cfg_data;
    logic        i_in_valid;
    logic        o_in_stall;
    t_in         i_in_data;
    logic        o_out_valid;
    logic        i_out_stall;
    t_out        o_out_data;

    bldc_commutation_speed_position_ctrl DUT (.*);

    always begin
        i_clk = 1'b1; #5;
        i_clk = 1'b0; #5;
    end

    // motor model state
    logic [2:0]   m_mode;
    logic signed [31:0] m_tgt_speed, m_tgt_pos;
    logic [23:0]  m_skp, m_ski, m_pkp, m_pkd;
    logic [15:0]  m_max_duty;
    logic [2:0]   m_rotor;
    logic [31:0]  m_count, m_tick_count;
    logic         m_fwd;
    longint       m_integral, m_last_perr;
    logic [15:0]  m_duty;
    logic signed [31:0] m_vel;
    logic [5:0]   m_drive;

    t_in    pending_requests[$];
    t_out   expected_results[$];
    int     error_count = 0;
    longint cycle_count = 0;
    int     hold_off = 0;

    function automatic longint sat32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint cap_duty(longint unsigned mag);
        return (mag > m_max_duty) ? m_max_duty : mag;
    endfunction

    function automatic longint velocity_of(logic [19:0] iv);
        longint delta;
        longint unsigned den, mag, q, r, v;
        delta = $signed(m_count - m_tick_count);
        den = 6 * ((iv == 0) ? 1 : iv);
        mag = (delta < 0 ? -delta : delta) * 1000000;
        q = mag / den;
        r = mag % den;
        if (q >= (64'd1 << (31 - FB))) v = 64'd1 << 31;
        else v = (q << FB) + ((r << FB) / den);
        if (delta < 0) return (v > (64'd1 << 31)) ? -64'sd2147483648 : -longint'(v);
        return (v > 64'd2147483647) ? 64'sd2147483647 : longint'(v);
    endfunction

    function automatic longint speed_duty(longint v);
        longint tgt, lim, err, raw;
        tgt = m_tgt_speed;
        lim = longint'(ILIM) << FB;
        if (lim > 64'sd2147483647) lim = 64'sd2147483647;
        if (tgt == 0) return m_max_duty;
        m_fwd = tgt > 0;
        err = (tgt < 0 ? -tgt : tgt) - (v < 0 ? -v : v);
        m_integral += err * 10;
        if (m_integral > lim) m_integral = lim;
        if (m_integral < -lim) m_integral = -lim;
        raw = longint'(m_skp) * err + longint'(m_ski) * m_integral;
        if (raw <= 0) return 0;
        return cap_duty(longint'(raw) >>> FB);
    endfunction

    function automatic longint position_duty();
        longint here, err, diff, raw;
        here = (longint'($signed(m_count)) * (longint'(1) << FB)) / 6;
        err = sat32(longint'(m_tgt_pos) - here);
        diff = err - m_last_perr;
        raw = longint'(m_pkp) * err + longint'(m_pkd) * diff;
        m_last_perr = err;
        m_fwd = raw >= 0;
        return cap_duty((raw < 0 ? -raw : raw) >>> FB);
    endfunction

    function automatic t_out commutate(t_in req);
        t_out res;
        logic [2:0] rot;
        int d;
        longint v, vd, rd;
        res.hall_invalid = 1'b0;
        if (req.kind == 1'b0) begin
            rot = ROTOR_TBL[req.hall_bits];
            if (rot > 3'd5) begin
                res.hall_invalid = 1'b1;
                m_drive = 6'h00;
            end else begin
                d = int'(rot) - int'(m_rotor);
                m_drive = DRIVE_TBL[3'((rot + (m_fwd ? 2 : 4)) % 6)];
                if (d == 5) m_count = m_count - 1;
                else if (d == -5) m_count = m_count + 1;
                else m_count = m_count + d;
                m_rotor = rot;
            end
        end else begin
            v = velocity_of(req.interval_us);
            m_vel = 32'(v);
            m_tick_count = m_count;
            case (m_mode)
                MODE_FULL: m_duty = m_max_duty;
                MODE_SPEED: m_duty = 16'(speed_duty(v));
                MODE_POS: m_duty = 16'(position_duty());
                MODE_BOTH: begin
                    vd = speed_duty(v);
                    rd = position_duty();
                    if (v >= 0) m_duty = 16'((vd < rd) ? vd : rd);
                    else m_duty = 16'((vd > rd) ? vd : rd);
                end
                default: ;
            endcase
        end
        res.drive_pattern = m_drive;
        res.duty = m_duty;
        res.position = m_count;
        res.velocity = m_vel;
        res.forward = m_fwd;
        return res;
    endfunction

    function automatic int gap_len();
        if ($urandom_range(0, 2) == 0) return 0;
        if ($urandom_range(0, 19) == 0) return $urandom_range(10, 60);
        return $urandom_range(0, 3);
    endfunction

    // request driver
    int in_gap = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (i_in_valid && o_in_stall) begin
        end else begin
            if (i_in_valid) in_gap = gap_len();
            if (in_gap > 0) begin
                in_gap--;
                i_in_valid <= 1'b0;
            end else if (pending_requests.size() > 0) begin
                t_in r;
                r = pending_requests.pop_front();
                expected_results.push_back(commutate(r));
                i_in_data <= r;
                i_in_valid <= 1'b1;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // result monitor and stall
    int out_gap = 0;
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            t_out e;
            if (expected_results.size() == 0) begin
                $error("result with no request outstanding");
                error_count++;
            end else begin
                e = expected_results.pop_front();
                if (o_out_data.drive_pattern !== e.drive_pattern) begin
                    $error("drive_pattern exp %h got %h", e.drive_pattern,
                           o_out_data.drive_pattern); error_count++; end
                if (o_out_data.duty !== e.duty) begin
                    $error("duty exp %h got %h", e.duty, o_out_data.duty);
                    error_count++; end
                if (o_out_data.position !== e.position) begin
                    $error("position exp %h got %h", e.position, o_out_data.position);
                    error_count++; end
                if (o_out_data.velocity !== e.velocity) begin
                    $error("velocity exp %h got %h", e.velocity, o_out_data.velocity);
                    error_count++; end
                if (o_out_data.forward !== e.forward) begin
                    $error("forward exp %b got %b", e.forward, o_out_data.forward);
                    error_count++; end
                if (o_out_data.hall_invalid !== e.hall_invalid) begin
                    $error("hall_invalid exp %b got %b", e.hall_invalid,
                           o_out_data.hall_invalid); error_count++; end
            end
        end
        if (hold_off > 0) begin
            hold_off--;
            i_out_stall <= 1'b1;
        end else if (out_gap > 0) begin
            out_gap--;
            i_out_stall <= 1'b1;
        end else begin
            out_gap = gap_len();
            i_out_stall <= 1'b0;
        end
    end

    task automatic write_reg(logic [2:0] idx, logic [31:0] val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        case (idx)
            REG_MODE: m_mode = val[2:0];
            REG_TGT_SPEED: m_tgt_speed = val;
            REG_TGT_POS: m_tgt_pos = val;
            REG_SPEED_KP: m_skp = val[23:0];
            REG_SPEED_KI: m_ski = val[23:0];
            REG_POS_KP: m_pkp = val[23:0];
            REG_POS_KD: m_pkd = val[23:0];
            default: m_max_duty = val[15:0];
        endcase
    endtask

    task automatic drain();
        while (pending_requests.size() > 0 || expected_results.size() > 0 || i_in_valid)
            @(posedge i_clk);
        repeat (200) @(posedge i_clk);
    endtask

    function automatic t_in hall_req(logic [2:0] h);
        t_in r;
        r.kind = 1'b0; r.hall_bits = h; r.interval_us = 20'($urandom);
        return r;
    endfunction

    function automatic t_in tick_req(logic [19:0] iv);
        t_in r;
        r.kind = 1'b1; r.hall_bits = 3'($urandom); r.interval_us = iv;
        return r;
    endfunction

    // forward sequence of hall codes: states 0..5
    logic [2:0] hall_seq [6] = '{3'd5, 3'd4, 3'd6, 3'd2, 3'd3, 3'd1};

    task automatic random_phase(int n);
        int k, p;
        bit dir;
        p = $urandom_range(0, 5);
        dir = 1'($urandom);
        for (k = 0; k < n; k++) begin
            case ($urandom_range(0, 9))
                0: pending_requests.push_back(hall_req(3'($urandom)));
                1, 2: pending_requests.push_back(tick_req(
                    ($urandom_range(0, 3) == 0) ? 20'($urandom) : 20'($urandom_range(0, 3000))));
                default: begin
                    if ($urandom_range(0, 15) == 0) dir = ~dir;
                    p = dir ? (p + 1) % 6 : (p + 5) % 6;
                    pending_requests.push_back(hall_req(hall_seq[p]));
                end
            endcase
        end
    endtask

    int i, ph;
    initial begin
        i_rst_n = 1'b0;
        i_cfg_valid = 1'b0; i_cfg_index = '0; i_cfg_data = '0;
        i_in_valid = 1'b0; i_in_data = '0; i_out_stall = 1'b0;
        m_mode = MODE_HOLD; m_tgt_speed = 0; m_tgt_pos = 0;
        m_skp = 0; m_ski = 0; m_pkp = 0; m_pkd = 0; m_max_duty = 16'hffff;
        m_rotor = 0; m_count = 0; m_tick_count = 0; m_fwd = 1'b1;
        m_integral = 0; m_last_perr = 0; m_duty = 0; m_vel = 0; m_drive = 0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: every hall code, tick extremes, modes hold, full, speed, both and unused code 7
        for (i = 0; i < 8; i++) pending_requests.push_back(hall_req(i[2:0]));
        pending_requests.push_back(tick_req(20'd0));
        pending_requests.push_back(tick_req(20'hfffff));
        for (i = 0; i < 6; i++) pending_requests.push_back(hall_req(hall_seq[i]));
        pending_requests.push_back(tick_req(20'd1));
        drain();
        write_reg(REG_MODE, 32'(MODE_FULL));
        write_reg(REG_MAX_DUTY, 32'h1234);
        pending_requests.push_back(tick_req(20'd100));
        drain();
        write_reg(REG_MODE, 32'(MODE_SPEED));
        pending_requests.push_back(tick_req(20'd100));
        drain();
        write_reg(REG_TGT_SPEED, 32'h8000_0000);
        write_reg(REG_SPEED_KP, 32'hffffff);
        write_reg(REG_SPEED_KI, 32'hffffff);
        write_reg(REG_MAX_DUTY, 32'hffff);
        pending_requests.push_back(tick_req(20'd1));
        drain();
        write_reg(REG_MODE, 32'(MODE_BOTH));
        write_reg(REG_TGT_POS, 32'h7fff_ffff);
        write_reg(REG_POS_KP, 32'hffffff);
        write_reg(REG_POS_KD, 32'hffffff);
        pending_requests.push_back(tick_req(20'd50));
        pending_requests.push_back(hall_req(3'd7));
        pending_requests.push_back(tick_req(20'd50));
        drain();
        write_reg(REG_MODE, 32'd7);
        pending_requests.push_back(tick_req(20'd5));
        drain();

        // random phases with changing settings; long receiver hold-off in phase 0
        for (ph = 0; ph < 16; ph++) begin
            write_reg(REG_MODE, $urandom_range(0, 7));
            write_reg(REG_TGT_SPEED, (ph % 4 == 0) ? 32'd0 :
                      $signed(32'($urandom_range(0, 1 << 24))) * (($urandom & 1) ? 1 : -1));
            write_reg(REG_TGT_POS, (ph == 3) ? 32'h8000_0000 :
                      32'($signed(32'($urandom_range(0, 1 << 22))) - (1 << 21)));
            write_reg(REG_SPEED_KP, (ph == 5) ? 32'h0 : $urandom_range(0, 24'hffffff));
            write_reg(REG_SPEED_KI, $urandom_range(0, 24'h3ffff));
            write_reg(REG_POS_KP, (ph == 6) ? 32'hffffff : $urandom_range(0, 24'hfffff));
            write_reg(REG_POS_KD, $urandom_range(0, 24'hfffff));
            write_reg(REG_MAX_DUTY, (ph == 7) ? 32'h0 : $urandom_range(0, 16'hffff));
            if (ph == 0) hold_off = 400;
            random_phase(105);
            drain();
        end
        if (error_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end
endmodule

@@ files.f @@
hdl/bcsp_pkg.sv
hdl/bcsp_div.sv
hdl/bcsp_dp.sv
hdl/bcsp_ctrl.sv
hdl/bldc_commutation_speed_position_ctrl.sv
hdl/bcsp_chk.sv
bench/bldc_commutation_speed_position_ctrl_test.sv
